@@ design/sms_pkg.sv @@
// Shared types, constants and register map of the sumo motor command sequencer.
package sms_pkg;

    // Width of the phase timer and of the charge-hold age counter
    localparam int TIMER_BITS = 16;
    // Width of the tick-count configuration registers
    localparam int TICK_W     = 16;
    // Width of a motor speed
    localparam int SPEED_W    = 8;
    // APB geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    typedef logic [TIMER_BITS-1:0]       t_ticks;
    typedef logic [TICK_W-1:0]           t_cfg_ticks;
    typedef logic signed [SPEED_W-1:0]   t_speed;

    // Full speed, both directions
    localparam t_speed SPEED_FULL     = 8'sd100;
    localparam t_speed SPEED_NEG_FULL = -8'sd100;
    localparam t_speed SPEED_STOP     = 8'sd0;

    // Register reset values
    localparam t_cfg_ticks RST_DEADTIME    = 16'd50;
    localparam t_cfg_ticks RST_REVERSE     = 16'd250;
    localparam t_cfg_ticks RST_SPIN        = 16'd200;
    localparam t_cfg_ticks RST_CHARGE_HOLD = 16'd200;
    localparam t_speed     RST_SEARCH      = 8'sd60;
    localparam t_speed     RST_COUNTER     = 8'sd20;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DEADTIME     = 3'd0,
        REG_REVERSE      = 3'd1,
        REG_SPIN         = 3'd2,
        REG_CHARGE_HOLD  = 3'd3,
        REG_SEARCH_SPEED = 3'd4,
        REG_COUNTER_TURN = 3'd5
    } t_reg_idx;

    // Sequencer phases
    typedef enum logic [2:0] {
        PH_DECIDE    = 3'd0,
        PH_DEAD_CMD  = 3'd1,
        PH_DEAD_BACK = 3'd2,
        PH_REVERSE   = 3'd3,
        PH_DEAD_SPIN = 3'd4,
        PH_SPIN      = 3'd5
    } t_phase;

    // Configuration as seen by the sequencer (speeds already clamped)
    typedef struct packed {
        t_cfg_ticks deadtime;
        t_cfg_ticks reverse;
        t_cfg_ticks spin;
        t_cfg_ticks charge_hold;
        t_speed     search_speed;
        t_speed     counter_turn;
    } t_cfg;

    // One tick of sensor flags
    typedef struct packed {
        logic enemy_close;
        logic bumper_right;
        logic bumper_left;
        logic line_detected;
    } t_sense;

    // One tick of motor command
    typedef struct packed {
        logic   attacking;
        logic   busy_res;
        t_speed right_speed;
        t_speed left_speed;
    } t_result;

endpackage

@@ design/sms_cfg.sv @@
// APB configuration registers with speed clamping.
module sms_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output sms_pkg::t_cfg                   o_cfg
);
    import sms_pkg::*;

    t_cfg_ticks r_deadtime, r_reverse, r_spin, r_charge_hold;
    t_speed     r_search, r_counter;
    t_reg_idx   idx;
    logic       wr_en;

    // clamp a raw speed register to -100..100
    function automatic t_speed clamp_speed(input t_speed v);
        t_speed res;
        res = v;
        if (v > SPEED_FULL) res = SPEED_FULL;
        else if (v < SPEED_NEG_FULL) res = SPEED_NEG_FULL;
        return res;
    endfunction

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadtime    <= RST_DEADTIME;
            r_reverse     <= RST_REVERSE;
            r_spin        <= RST_SPIN;
            r_charge_hold <= RST_CHARGE_HOLD;
            r_search      <= RST_SEARCH;
            r_counter     <= RST_COUNTER;
        end else if (wr_en) begin
            case (idx)
                REG_DEADTIME:     r_deadtime    <= pwdata[TICK_W-1:0];
                REG_REVERSE:      r_reverse     <= pwdata[TICK_W-1:0];
                REG_SPIN:         r_spin        <= pwdata[TICK_W-1:0];
                REG_CHARGE_HOLD:  r_charge_hold <= pwdata[TICK_W-1:0];
                REG_SEARCH_SPEED: r_search      <= t_speed'(pwdata[SPEED_W-1:0]);
                REG_COUNTER_TURN: r_counter     <= t_speed'(pwdata[SPEED_W-1:0]);
                default: ;
            endcase
        end
    end

    // read mux, raw stored values
    always_comb begin
        prdata = '0;
        case (idx)
            REG_DEADTIME:     prdata = APB_DATA_W'(r_deadtime);
            REG_REVERSE:      prdata = APB_DATA_W'(r_reverse);
            REG_SPIN:         prdata = APB_DATA_W'(r_spin);
            REG_CHARGE_HOLD:  prdata = APB_DATA_W'(r_charge_hold);
            REG_SEARCH_SPEED: prdata = APB_DATA_W'(unsigned'(r_search));
            REG_COUNTER_TURN: prdata = APB_DATA_W'(unsigned'(r_counter));
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.deadtime     = r_deadtime;
    assign o_cfg.reverse      = r_reverse;
    assign o_cfg.spin         = r_spin;
    assign o_cfg.charge_hold  = r_charge_hold;
    assign o_cfg.search_speed = clamp_speed(r_search);
    assign o_cfg.counter_turn = clamp_speed(r_counter);

endmodule

@@ design/sms_step.sv @@
// Sequencer state and the per-tick command decision.
module sms_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sms_pkg::t_sense  i_sense,
    input  sms_pkg::t_cfg    i_cfg,
    output sms_pkg::t_result o_result
);
    import sms_pkg::*;

    localparam int CMP_W = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
    localparam t_ticks AGE_MAX = '1;

    t_phase r_phase, n_phase;
    t_ticks r_timer, n_timer;
    t_speed r_pend_l, n_pend_l, r_pend_r, n_pend_r;
    t_speed r_last_l, n_last_l, r_last_r, n_last_r;
    logic   r_flag, n_flag;
    t_ticks r_age, n_age;

    t_ticks     age_inc;
    logic       timed;
    logic       hold;
    // decision of a deciding tick
    t_speed     dec_l, dec_r;
    t_phase     dec_dead, dec_run;
    t_cfg_ticks dec_len;
    logic       dec_flag, dec_age_clr;
    // staged command
    logic       do_stage, do_decide;
    t_speed     src_l, src_r, cmd_l, cmd_r;
    t_phase     cmd_dead, cmd_run;
    t_cfg_ticks cmd_len;
    t_speed     res_l, res_r;

    // opposite nonzero signs
    function automatic logic flips(input t_speed a, input t_speed b);
        return (a[SPEED_W-1] ^ b[SPEED_W-1]) && (a != SPEED_STOP) && (b != SPEED_STOP);
    endfunction

    // phase length minus one, zero counts as one tick
    function automatic t_ticks load_len(input t_cfg_ticks d);
        t_cfg_ticks dm;
        dm = (d == '0) ? '0 : d - 1'b1;
        return t_ticks'(dm);
    endfunction

    assign age_inc = (r_age != AGE_MAX) ? r_age + 1'b1 : r_age;
    assign timed   = (r_phase == PH_DEAD_CMD || r_phase == PH_DEAD_BACK ||
                      r_phase == PH_REVERSE  || r_phase == PH_DEAD_SPIN ||
                      r_phase == PH_SPIN) && (r_timer != '0);
    assign hold    = r_flag && (CMP_W'(age_inc) < CMP_W'(i_cfg.charge_hold));

    // priority decision: line, bumpers, enemy, charge hold, search
    always_comb begin
        dec_dead    = PH_DEAD_CMD;
        dec_run     = PH_DECIDE;
        dec_len     = '0;
        dec_flag    = r_flag;
        dec_age_clr = 1'b0;
        dec_l       = SPEED_FULL;
        dec_r       = SPEED_NEG_FULL;
        priority if (i_sense.line_detected) begin
            dec_flag = 1'b0;
            dec_l    = SPEED_NEG_FULL;
            dec_r    = SPEED_NEG_FULL;
            dec_dead = PH_DEAD_BACK;
            dec_run  = PH_REVERSE;
            dec_len  = i_cfg.reverse;
        end else if (i_sense.bumper_left || i_sense.bumper_right || i_sense.enemy_close) begin
            dec_flag    = 1'b1;
            dec_age_clr = 1'b1;
            if (i_sense.bumper_left && !i_sense.bumper_right) begin
                dec_l = i_cfg.counter_turn;
            end else if (i_sense.bumper_right && !i_sense.bumper_left) begin
                dec_r = -i_cfg.counter_turn;
            end
        end else if (hold) begin
            dec_l = SPEED_FULL;
        end else begin
            dec_flag = 1'b0;
            dec_l    = i_cfg.search_speed;
            dec_r    = i_cfg.search_speed;
        end
    end

    // next state and result
    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_pend_l  = r_pend_l;
        n_pend_r  = r_pend_r;
        n_last_l  = r_last_l;
        n_last_r  = r_last_r;
        n_flag    = r_flag;
        n_age     = age_inc;
        res_l     = SPEED_STOP;
        res_r     = SPEED_STOP;
        do_stage  = 1'b0;
        do_decide = 1'b0;
        src_l     = r_last_l;
        src_r     = r_last_r;
        cmd_l     = dec_l;
        cmd_r     = dec_r;
        cmd_dead  = dec_dead;
        cmd_run   = dec_run;
        cmd_len   = dec_len;

        if (timed) begin
            n_timer = r_timer - 1'b1;
            if (r_phase == PH_REVERSE || r_phase == PH_SPIN) begin
                res_l = r_last_l;
                res_r = r_last_r;
            end
        end else begin
            case (r_phase)
                PH_DEAD_CMD: begin
                    src_l     = r_pend_l;
                    src_r     = r_pend_r;
                    do_stage  = 1'b1;
                    do_decide = 1'b1;
                end
                PH_DEAD_BACK, PH_DEAD_SPIN: begin
                    n_last_l = r_pend_l;
                    n_last_r = r_pend_r;
                    res_l    = r_pend_l;
                    res_r    = r_pend_r;
                    if (r_phase == PH_DEAD_BACK) begin
                        n_phase = PH_REVERSE;
                        n_timer = load_len(i_cfg.reverse);
                    end else begin
                        n_phase = PH_SPIN;
                        n_timer = load_len(i_cfg.spin);
                    end
                end
                PH_REVERSE: begin
                    do_stage = 1'b1;
                    cmd_l    = SPEED_FULL;
                    cmd_r    = SPEED_NEG_FULL;
                    cmd_dead = PH_DEAD_SPIN;
                    cmd_run  = PH_SPIN;
                    cmd_len  = i_cfg.spin;
                end
                default: begin
                    do_stage  = 1'b1;
                    do_decide = 1'b1;
                end
            endcase

            if (do_decide) begin
                n_flag = dec_flag;
                if (dec_age_clr) n_age = '0;
            end

            // start a command, stopping first on a sign reversal when the deadtime is nonzero
            if (do_stage) begin
                n_pend_l = cmd_l;
                n_pend_r = cmd_r;
                if ((flips(src_l, cmd_l) || flips(src_r, cmd_r)) &&
                    (i_cfg.deadtime != '0)) begin
                    n_phase  = cmd_dead;
                    n_timer  = t_ticks'(i_cfg.deadtime - 1'b1);
                    n_last_l = src_l;
                    n_last_r = src_r;
                end else begin
                    n_last_l = cmd_l;
                    n_last_r = cmd_r;
                    n_phase  = cmd_run;
                    n_timer  = (cmd_run == PH_DECIDE) ? '0 : load_len(cmd_len);
                    res_l    = cmd_l;
                    res_r    = cmd_r;
                end
            end
        end
    end

    // state registers, advance once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DECIDE;
            r_timer  <= '0;
            r_pend_l <= SPEED_STOP;
            r_pend_r <= SPEED_STOP;
            r_last_l <= SPEED_STOP;
            r_last_r <= SPEED_STOP;
            r_flag   <= 1'b0;
            r_age    <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_pend_l <= n_pend_l;
            r_pend_r <= n_pend_r;
            r_last_l <= n_last_l;
            r_last_r <= n_last_r;
            r_flag   <= n_flag;
            r_age    <= n_age;
        end
    end

    assign o_result.left_speed  = res_l;
    assign o_result.right_speed = res_r;
    assign o_result.busy_res    = (n_phase != PH_DECIDE);
    assign o_result.attacking   = n_flag;

endmodule

@@ design/sumo_motor_command_sequencer_core.sv @@
// Top level of the sumo motor command sequencer: stream ports, input and result registers.
//
// One transaction per clock in steady state while the output takes each result: a tick
// is taken into the input register, its command is worked out from the sequencer state
// while it sits there and is written to the result register when the tick advances.
// The single state update per tick sets the rate; the input side keeps accepting while
// a result waits on the output, and stalls only when both registers are full and the
// output does not take the waiting result.
module sumo_motor_command_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input ticks
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // line_detected, bumper_left,
                                                        // bumper_right, enemy_close, pad
    // motor commands
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [23:0]                     o_m_tdata,  // left_speed[7:0], right_speed[15:8],
                                                        // busy_res[16], attacking[17], pad
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sms_pkg::*;

    t_cfg    cfg;
    t_sense  r_in;
    logic    r_in_valid;
    t_result step_res;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;

    sms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // tick moves from input register to result register
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    sms_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_sense  (r_in),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= t_sense'(i_s_tdata[3:0]);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out};

endmodule
